/* design/llpp_pkg.sv */
// Package for the LL(1) predictive parse engine: item types, codes, constants.
// No dependencies.
package llpp_pkg;

  localparam int NONTERMINALS_DEF = 16;
  localparam int TERMINALS_DEF    = 16;
  localparam int STACK_DEPTH_DEF  = 64;
  localparam int MAX_RHS_DEF      = 8;
  localparam int SYM_W            = 5;
  localparam int RHS_BITS         = 40;
  localparam int RESULT_LIMIT     = 18;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_FEED  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_APPLIED  = 3'd0,
    K_MATCHED  = 3'd1,
    K_ACCEPTED = 3'd2,
    K_MISMATCH = 3'd3,
    K_EMPTY    = 3'd4,
    K_OVERFLOW = 3'd5
  } kind_t;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_GOK   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  row_nonterminal;
    logic [3:0]  terminal;
    logic        entry_valid;
    logic [3:0]  rhs_length;
    logic [39:0] rhs_symbols;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  lhs_nonterminal;
    logic [3:0]  out_rhs_length;
    logic [39:0] out_rhs_symbols;
    logic [3:0]  matched_terminal;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_LOOK,
    S_PUSH,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // latch input item
    logic do_load;   // write table cell
    logic do_start;  // reset stack for a new parse
    logic rd_top;    // read stack top
    logic rd_tab;    // read table cell
    logic pop;       // pop top (match)
    logic push;      // push one symbol of right side
    logic exp_pop;   // pop nonterminal before expansion
    logic end_parse; // drop active
    logic set_res;   // build result register
    logic [2:0] kind;
    logic res_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic active;
    logic t_oor;
    logic sp_zero;
    logic is_end;
    logic top_nt;
    logic top_match;
    logic cell_ok;
    logic ovf;
    logic push_done;
    logic budget;
  } sts_t;

endpackage

/* design/llpp_datapath.sv */
// Datapath of the LL(1) parse engine: parse table, symbol stack, result register.
// Depends on llpp_pkg.
module llpp_datapath #(
  parameter int NONTERMINALS = llpp_pkg::NONTERMINALS_DEF,
  parameter int TERMINALS    = llpp_pkg::TERMINALS_DEF,
  parameter int STACK_DEPTH  = llpp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RHS      = llpp_pkg::MAX_RHS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  llpp_pkg::in_item_t  in_item,
  input  llpp_pkg::cmd_t      cmd,
  input  logic [3:0]          start_nt,
  input  logic [3:0]          end_marker,
  input  logic                grammar_ok,
  output llpp_pkg::sts_t      sts,
  output llpp_pkg::out_item_t res
);
  localparam int CELLS = 256;
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int SIW   = $clog2(STACK_DEPTH);
  localparam int TW    = 4 + 40;

  logic [TW-1:0] table_mem [CELLS];
  logic [CELLS-1:0] cell_valid;
  logic [4:0] stack_mem [STACK_DEPTH];

  llpp_pkg::in_item_t item;
  logic [SPW-1:0] sp;
  logic active;
  logic [4:0] top;
  logic [TW-1:0] tab_q;
  logic [3:0] push_cnt;
  logic [4:0] n_res;

  logic [7:0] ld_addr, rd_addr;
  logic [3:0] ld_len;
  logic [39:0] ld_mask;
  logic [3:0] cell_len;
  logic [39:0] cell_syms;
  logic [4:0] push_sym;
  logic [SPW:0] sp_after;

  always_comb begin
    ld_len = (item.rhs_length > 4'(MAX_RHS)) ? 4'(MAX_RHS) : item.rhs_length;
    for (int k = 0; k < 8; k++) begin
      ld_mask[k*5 +: 5] = (4'(k) < ld_len) ? 5'h1f : 5'h0;
    end
    ld_addr  = {item.row_nonterminal, item.terminal};
    rd_addr  = {top[3:0], item.terminal};
    cell_len = tab_q[43:40];
    cell_syms = tab_q[39:0];
    push_sym = cell_syms[(push_cnt - 4'd1) * 5 +: 5];
    sp_after = {1'b0, sp} + {{(SPW-3){1'b0}}, cell_len} - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
      sp <= '0;
      active <= 1'b0;
      n_res <= '0;
    end else begin
      if (cmd.do_load && 32'(item.row_nonterminal) < NONTERMINALS &&
          32'(item.terminal) < TERMINALS) begin
        cell_valid[ld_addr] <= item.entry_valid;
      end
      if (cmd.do_start && grammar_ok) begin
        sp <= SPW'(1);
        active <= 1'b1;
      end
      if (cmd.take) n_res <= '0;
      if (cmd.set_res) n_res <= n_res + 5'd1;
      if (cmd.pop || cmd.exp_pop) sp <= sp - 1'b1;
      if (cmd.push) sp <= sp + 1'b1;
      if (cmd.end_parse) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) item <= in_item;
    if (cmd.do_load) begin
      table_mem[ld_addr] <= {item.entry_valid ? ld_len : 4'd0,
                             item.entry_valid ? (item.rhs_symbols & ld_mask) : 40'd0};
    end
    if (cmd.do_start && grammar_ok) stack_mem[0] <= {1'b1, start_nt};
    if (cmd.push) stack_mem[sp[SIW-1:0]] <= push_sym;
    if (cmd.rd_top) top <= stack_mem[SIW'(sp - 1'b1)];
    if (cmd.rd_tab) begin
      tab_q <= table_mem[rd_addr];
      push_cnt <= table_mem[rd_addr][43:40];
    end
    if (cmd.push) push_cnt <= push_cnt - 4'd1;
    if (cmd.set_res) begin
      res.kind <= cmd.kind;
      res.matched_terminal <= item.terminal;
      res.last <= cmd.res_last;
      if (cmd.kind == llpp_pkg::K_APPLIED) begin
        res.lhs_nonterminal <= top[3:0];
        res.out_rhs_length  <= cell_len;
        res.out_rhs_symbols <= cell_syms;
      end else if (cmd.kind == llpp_pkg::K_EMPTY ||
                   cmd.kind == llpp_pkg::K_OVERFLOW) begin
        res.lhs_nonterminal <= top[3:0];
        res.out_rhs_length  <= '0;
        res.out_rhs_symbols <= '0;
      end else begin
        res.lhs_nonterminal <= '0;
        res.out_rhs_length  <= '0;
        res.out_rhs_symbols <= '0;
      end
    end
  end

  always_comb begin
    sts.op        = item.op;
    sts.active    = active;
    sts.t_oor     = 32'(item.terminal) >= TERMINALS;
    sts.sp_zero   = (sp == '0);
    sts.is_end    = (item.terminal == end_marker);
    sts.top_nt    = top[4];
    sts.top_match = (top[3:0] == item.terminal);
    sts.cell_ok   = (32'(top[3:0]) < NONTERMINALS) && cell_valid[rd_addr];
    sts.ovf       = sp_after > (SPW+1)'(STACK_DEPTH);
    sts.push_done = (push_cnt == 4'd0);
    sts.budget    = (n_res >= 5'(llpp_pkg::RESULT_LIMIT - 1));
  end

endmodule

/* design/llpp_ctrl.sv */
// Controller state machine of the LL(1) parse engine.
// Depends on llpp_pkg.
module llpp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  llpp_pkg::sts_t sts,
  output llpp_pkg::cmd_t cmd
);
  llpp_pkg::state_t state, state_next;
  logic rv, rv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llpp_pkg::S_IDLE;
      rv <= 1'b0;
    end else begin
      state <= state_next;
      rv <= rv_next;
    end
  end

  assign out_valid = rv;

  // emit helper: result register is free when empty or being taken
  logic res_free;
  assign res_free = !rv || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    rv_next = rv && !out_ready;
    unique case (state)
      llpp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = llpp_pkg::S_TOP;
        end
      end
      llpp_pkg::S_TOP: begin
        // decode latched item
        unique case (llpp_pkg::op_t'(sts.op))
          llpp_pkg::OP_LOAD: begin
            cmd.do_load = 1'b1;
            state_next = llpp_pkg::S_IDLE;
          end
          llpp_pkg::OP_START: begin
            cmd.do_start = 1'b1;
            state_next = llpp_pkg::S_IDLE;
          end
          llpp_pkg::OP_FEED: begin
            if (!sts.active) state_next = llpp_pkg::S_IDLE;
            else begin
              cmd.rd_top = 1'b1;
              state_next = llpp_pkg::S_LOOK;
            end
          end
          default: state_next = llpp_pkg::S_IDLE;
        endcase
      end
      llpp_pkg::S_LOOK: begin
        cmd.rd_tab = 1'b1;
        state_next = llpp_pkg::S_EMIT;
      end
      llpp_pkg::S_EMIT: begin
        if (res_free) begin
          cmd.set_res = 1'b1;
          cmd.res_last = 1'b1;
          rv_next = 1'b1;
          state_next = llpp_pkg::S_IDLE;
          if (sts.t_oor) begin
            cmd.kind = llpp_pkg::K_MISMATCH;
            cmd.end_parse = 1'b1;
          end else if (sts.sp_zero) begin
            cmd.kind = sts.is_end ? llpp_pkg::K_ACCEPTED : llpp_pkg::K_MISMATCH;
            cmd.end_parse = 1'b1;
          end else if (!sts.top_nt) begin
            if (sts.top_match) begin
              cmd.kind = llpp_pkg::K_MATCHED;
              cmd.pop = 1'b1;
            end else begin
              cmd.kind = llpp_pkg::K_MISMATCH;
              cmd.end_parse = 1'b1;
            end
          end else if (sts.budget || (sts.cell_ok && sts.ovf)) begin
            cmd.kind = llpp_pkg::K_OVERFLOW;
            cmd.end_parse = 1'b1;
          end else if (!sts.cell_ok) begin
            cmd.kind = llpp_pkg::K_EMPTY;
            cmd.end_parse = 1'b1;
          end else begin
            cmd.kind = llpp_pkg::K_APPLIED;
            cmd.res_last = 1'b0;
            cmd.exp_pop = 1'b1;
            state_next = llpp_pkg::S_PUSH;
          end
        end
      end
      llpp_pkg::S_PUSH: begin
        if (sts.push_done) begin
          cmd.rd_top = 1'b1;
          state_next = llpp_pkg::S_LOOK;
        end else begin
          cmd.push = 1'b1;
        end
      end
      default: state_next = llpp_pkg::S_IDLE;
    endcase
  end

  // a new item is taken only with the engine idle
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> state == llpp_pkg::S_IDLE) else $error("take outside idle");
  // result register never overwritten while still waiting
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    cmd.set_res |-> (!rv || out_ready)) else $error("result clobbered");
  // push and pop never in the same cycle
  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && (cmd.pop || cmd.exp_pop))) else $error("push and pop together");

endmodule

/* design/ll1_predictive_parse_engine_unit.sv */
// Top level of the LL(1) table-driven predictive parse engine.
// Depends on llpp_pkg, llpp_ctrl, llpp_datapath.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------
//   input    | in_valid / in_ready         | in_item   (llpp_pkg::in_item_t)
//   output   | out_valid / out_ready       | out_item  (llpp_pkg::out_item_t)
//   config   | psel penable pwrite pready  | paddr, pwdata, prdata
//
// Load, start and idle-feed items are taken and then decoded before the next item is
// accepted. A feed reads the stack top, reads the table cell and emits, once per result,
// and pushes the symbols of each production applied one at a time into the stack.
// Reset (rst, synchronous) empties the table via per-cell valid bits at once.
// A result waiting on out_ready stalls the sequencer at its emit step.
module ll1_predictive_parse_engine_unit #(
  parameter int NONTERMINALS = llpp_pkg::NONTERMINALS_DEF,
  parameter int TERMINALS    = llpp_pkg::TERMINALS_DEF,
  parameter int STACK_DEPTH  = llpp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RHS      = llpp_pkg::MAX_RHS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  llpp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output llpp_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [3:0] start_nt, end_marker;
  logic grammar_ok;
  llpp_pkg::cmd_t cmd;
  llpp_pkg::sts_t sts;

  assign pready = 1'b1;

  // config registers, word addressed
  always_ff @(posedge clk) begin
    if (rst) begin
      start_nt <= 4'd0;
      end_marker <= 4'd15;
      grammar_ok <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        llpp_pkg::REG_START: start_nt <= pwdata[3:0];
        llpp_pkg::REG_END:   end_marker <= pwdata[3:0];
        llpp_pkg::REG_GOK:   grammar_ok <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      llpp_pkg::REG_START: prdata = {28'd0, start_nt};
      llpp_pkg::REG_END:   prdata = {28'd0, end_marker};
      llpp_pkg::REG_GOK:   prdata = {31'd0, grammar_ok};
      default:             prdata = '0;
    endcase
  end

  llpp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  llpp_datapath #(
    .NONTERMINALS(NONTERMINALS), .TERMINALS(TERMINALS),
    .STACK_DEPTH(STACK_DEPTH), .MAX_RHS(MAX_RHS)
  ) u_dp (
    .clk, .rst, .in_item, .cmd, .start_nt, .end_marker, .grammar_ok,
    .sts, .res(out_item)
  );

endmodule

/* tb/sv/tb_ll1_predictive_parse_engine_unit.sv */
// Testbench for ll1_predictive_parse_engine_unit: random and directed items,
// predicted results checked in order. Depends on llpp_pkg and the RTL.
module tb_ll1_predictive_parse_engine_unit;

  localparam int IN_W = $bits(llpp_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  llpp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  llpp_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_taken = 1'b0;

  ll1_predictive_parse_engine_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser shadow state: table, stack and registers.
  logic        cell_set [256];
  logic [3:0]  cell_len [256];
  logic [39:0] cell_rhs [256];
  logic [4:0]  sym_stack [64];
  int          depth;
  logic        parsing;
  logic [3:0]  start_nt;
  logic [3:0]  end_term;
  logic        grammar_good;

  llpp_pkg::in_item_t  pending_items[$];
  llpp_pkg::out_item_t expected_results[$];
  int   send_idle_pct;
  int   recv_stall_pct;
  int   errors = 0;

  function automatic llpp_pkg::out_item_t make_result(logic [2:0] k, logic [3:0] lhs,
                                                      logic [3:0] len, logic [39:0] rhs,
                                                      logic [3:0] t);
    llpp_pkg::out_item_t r;
    r.kind = k;
    r.lhs_nonterminal = lhs;
    r.out_rhs_length = len;
    r.out_rhs_symbols = rhs;
    r.matched_terminal = t;
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the shadow parser by one item and queue the results it causes.
  task automatic predict_parse(input llpp_pkg::in_item_t it);
    llpp_pkg::out_item_t res[$];
    int c;
    int len;
    logic [4:0] top;
    logic [39:0] rhs;
    logic [3:0] t;
    bit done;
    t = it.terminal;
    if (it.op == llpp_pkg::OP_LOAD) begin
      c = it.row_nonterminal * 16 + it.terminal;
      if (!it.entry_valid) begin
        cell_set[c] = 1'b0; cell_len[c] = '0; cell_rhs[c] = '0;
      end else begin
        len = (it.rhs_length > 8) ? 8 : it.rhs_length;
        cell_set[c] = 1'b1;
        cell_len[c] = len[3:0];
        rhs = '0;
        for (int i = 0; i < 5 * len; i++) rhs[i] = it.rhs_symbols[i];
        cell_rhs[c] = rhs;
      end
      return;
    end
    if (it.op == llpp_pkg::OP_START) begin
      if (grammar_good) begin
        sym_stack[0] = {1'b1, start_nt};
        depth = 1;
        parsing = 1'b1;
      end
      return;
    end
    if (it.op != llpp_pkg::OP_FEED || !parsing) return;
    done = 1'b0;
    while (!done) begin
      if (depth == 0) begin
        res.push_back(make_result((t == end_term) ? llpp_pkg::K_ACCEPTED :
                                  llpp_pkg::K_MISMATCH, '0, '0, '0, t));
        parsing = 1'b0; done = 1'b1;
      end else begin
        top = sym_stack[depth - 1];
        if (!top[4]) begin
          if (top[3:0] == t) begin
            res.push_back(make_result(llpp_pkg::K_MATCHED, '0, '0, '0, t));
            depth--;
          end else begin
            res.push_back(make_result(llpp_pkg::K_MISMATCH, '0, '0, '0, t));
            parsing = 1'b0;
          end
          done = 1'b1;
        end else if (res.size() >= llpp_pkg::RESULT_LIMIT - 1) begin
          res.push_back(make_result(llpp_pkg::K_OVERFLOW, top[3:0], '0, '0, t));
          parsing = 1'b0; done = 1'b1;
        end else begin
          c = top[3:0] * 16 + t;
          if (!cell_set[c]) begin
            res.push_back(make_result(llpp_pkg::K_EMPTY, top[3:0], '0, '0, t));
            parsing = 1'b0; done = 1'b1;
          end else if (depth - 1 + cell_len[c] > 64) begin
            res.push_back(make_result(llpp_pkg::K_OVERFLOW, top[3:0], '0, '0, t));
            parsing = 1'b0; done = 1'b1;
          end else begin
            depth--;
            // Push right side last symbol first so the first lands on top.
            for (int k = cell_len[c]; k > 0; k--) begin
              sym_stack[depth] = cell_rhs[c][5*(k-1) +: 5];
              depth++;
            end
            res.push_back(make_result(llpp_pkg::K_APPLIED, top[3:0], cell_len[c],
                                      cell_rhs[c], t));
          end
        end
      end
    end
    res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  // Mark the edges at which the block takes an input item.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
  end

  // Driver: present queued items, predict on acceptance.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        predict_parse(in_item);
        void'(pending_items.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare every result with the oldest expectation.
  always @(posedge clk) begin
    llpp_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d", out_item.kind);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_item.kind); errors++;
        end
        if (out_item.lhs_nonterminal !== e.lhs_nonterminal) begin
          $error("lhs_nonterminal exp %0d got %0d", e.lhs_nonterminal,
                 out_item.lhs_nonterminal); errors++;
        end
        if (out_item.out_rhs_length !== e.out_rhs_length) begin
          $error("out_rhs_length exp %0d got %0d", e.out_rhs_length,
                 out_item.out_rhs_length); errors++;
        end
        if (out_item.out_rhs_symbols !== e.out_rhs_symbols) begin
          $error("out_rhs_symbols exp %h got %h", e.out_rhs_symbols,
                 out_item.out_rhs_symbols); errors++;
        end
        if (out_item.matched_terminal !== e.matched_terminal) begin
          $error("matched_terminal exp %0d got %0d", e.matched_terminal,
                 out_item.matched_terminal); errors++;
        end
        if (out_item.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_item.last); errors++;
        end
      end
    end
  end

  function automatic llpp_pkg::in_item_t load_item(logic [3:0] row, logic [3:0] t,
                                                   logic ev, logic [3:0] len,
                                                   logic [39:0] rhs);
    llpp_pkg::in_item_t it;
    it = '0;
    it.op = llpp_pkg::OP_LOAD; it.row_nonterminal = row; it.terminal = t;
    it.entry_valid = ev; it.rhs_length = len; it.rhs_symbols = rhs;
    return it;
  endfunction

  function automatic llpp_pkg::in_item_t ctl_item(llpp_pkg::op_t op, logic [3:0] t);
    llpp_pkg::in_item_t it;
    it = IN_W'({$urandom, $urandom});
    it.op = op; it.terminal = t;
    return it;
  endfunction

  function automatic logic [4:0] term_sym(logic [3:0] t);
    return {1'b0, t};
  endfunction

  function automatic logic [4:0] nt_sym(logic [3:0] n);
    return {1'b1, n};
  endfunction

  // Hold until every queued item is taken and every result has come back.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write a register over the setup/access sequence; block must be idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      llpp_pkg::REG_START: start_nt = val[3:0];
      llpp_pkg::REG_END:   end_term = val[3:0];
      default:             grammar_good = val[0];
    endcase
  endtask

  // Grammar E -> T E', E' -> + T E' | eps, T -> a | ( E ) with random
  // terminal codes; rows sit at the current start nonterminal.
  task automatic load_grammar(logic [3:0] s, logic [3:0] plus_t, logic [3:0] a_t,
                              logic [3:0] lp, logic [3:0] rp);
    logic [3:0] ep;
    logic [3:0] tn;
    ep = s + 4'd1; tn = s + 4'd2;
    pending_items.push_back(load_item(s, a_t, 1'b1, 4'd2,
                            {30'h0, nt_sym(ep), nt_sym(tn)}));
    pending_items.push_back(load_item(s, lp, 1'b1, 4'd2,
                            {30'h0, nt_sym(ep), nt_sym(tn)}));
    pending_items.push_back(load_item(ep, plus_t, 1'b1, 4'd3,
                            {25'h0, nt_sym(ep), nt_sym(tn), term_sym(plus_t)}));
    pending_items.push_back(load_item(ep, rp, 1'b1, 4'd0, 40'({$urandom, $urandom})));
    pending_items.push_back(load_item(ep, end_term, 1'b1, 4'd0, '0));
    pending_items.push_back(load_item(tn, a_t, 1'b1, 4'd1, {35'h0, term_sym(a_t)}));
    pending_items.push_back(load_item(tn, lp, 1'b1, 4'd3,
                            {25'h0, term_sym(rp), nt_sym(s), term_sym(lp)}));
  endtask

  // Queue a random sentence of the expression grammar, sometimes corrupted.
  task automatic queue_sentence(logic [3:0] plus_t, logic [3:0] a_t, logic [3:0] lp,
                                logic [3:0] rp);
    int nest;
    int terms;
    nest = 0;
    terms = $urandom_range(1, 5);
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    for (int i = 0; i < terms; i++) begin
      if (i > 0) pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, plus_t));
      if ($urandom_range(2) == 0 && nest < 3) begin
        pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, lp)); nest++;
      end
      pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, a_t));
      if (nest > 0 && $urandom_range(1)) begin
        pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, rp)); nest--;
      end
    end
    while (nest > 0) begin
      pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, rp)); nest--;
    end
    if ($urandom_range(4) == 0)
      pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'($urandom_range(15))));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, end_term));
  endtask

  initial begin
    logic [3:0] s;
    logic [4:0] n;
    int rnd;
    for (int i = 0; i < 256; i++) begin
      cell_set[i] = 1'b0; cell_len[i] = '0; cell_rhs[i] = '0;
    end
    depth = 0; parsing = 1'b0;
    start_nt = 4'd0; end_term = 4'd15; grammar_good = 1'b1;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: feed while idle, unknown op, epsilon start, immediate accept.
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd3));
    pending_items.push_back(ctl_item(llpp_pkg::OP_NONE, 4'd0));
    pending_items.push_back(load_item(4'd0, 4'd15, 1'b1, 4'd0, '1));
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd15));
    // Accept again, then a feed after the parse has ended.
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd15));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd15));
    // Empty cell, and a clear of a set cell.
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd4));
    pending_items.push_back(load_item(4'd0, 4'd15, 1'b0, 4'd0, '0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd15));
    // Long right side saturated: nonterminal 0 on terminal 0 pushes eight of itself,
    // so repeated expansion overflows the stack.
    pending_items.push_back(load_item(4'd0, 4'd0, 1'b1, 4'd15, {8{5'h10}}));
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd0));
    // Expansion budget: N1 -> N1 on terminal 1 loops until the budget runs out.
    pending_items.push_back(load_item(4'd1, 4'd1, 1'b1, 4'd1, {35'h0, 5'h11}));
    pending_items.push_back(load_item(4'd0, 4'd1, 1'b1, 4'd2, {30'h0, 5'h01, 5'h11}));
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd1));
    // Terminal match then mismatch on top terminal.
    pending_items.push_back(load_item(4'd0, 4'd2, 1'b1, 4'd2, {30'h0, 5'h03, 5'h02}));
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd2));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd7));
    drain();

    // Register extremes; grammar off ignores start items.
    write_reg(llpp_pkg::REG_GOK, 32'd0);
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd15));
    drain();
    write_reg(llpp_pkg::REG_GOK, 32'd1);
    write_reg(llpp_pkg::REG_START, 32'd15);
    write_reg(llpp_pkg::REG_END, 32'd0);
    pending_items.push_back(load_item(4'd15, 4'd0, 1'b1, 4'd1, {35'h0, 5'h1f}));
    pending_items.push_back(ctl_item(llpp_pkg::OP_START, 4'd0));
    pending_items.push_back(ctl_item(llpp_pkg::OP_FEED, 4'd0));
    drain();

    // Random phases: one per idling profile, each with fresh settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      s = 4'($urandom_range(0, 13));
      write_reg(llpp_pkg::REG_START, {28'h0, s});
      write_reg(llpp_pkg::REG_END, (ph == 3) ? 32'd15 : $urandom_range(15));
      load_grammar(s, end_term ^ 4'd1, end_term ^ 4'd2, end_term ^ 4'd3, end_term ^ 4'd4);
      rnd = 0;
      while (rnd < 60) begin
        if ($urandom_range(9) < 7) begin
          queue_sentence(end_term ^ 4'd1, end_term ^ 4'd2, end_term ^ 4'd3, end_term ^ 4'd4);
          rnd += 9;
        end else begin
          // Noise: random loads away from the grammar rows, random ops.
          llpp_pkg::in_item_t it;
          it = IN_W'({$urandom, $urandom});
          if (it.op == llpp_pkg::OP_LOAD) begin
            n = 5'($urandom_range(4));
            it.row_nonterminal = s + 4'd3 + n[3:0];
            if (it.row_nonterminal < s + 3) it.row_nonterminal = s + 4'd3;
          end
          pending_items.push_back(it);
          rnd++;
        end
      end
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
